FILE: rtl/dtp_pkg.sv
package dtp_pkg;

  // Frame geometry.
  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = 13;
  localparam int CNT_W   = 12;
  localparam int HALF_W  = 14;

  // Fixed-point formats.
  localparam int FRAC_BITS  = 16;
  localparam int PRE_SHIFT  = 16;
  localparam int POST_SHIFT = FRAC_BITS + 32 - PRE_SHIFT + 1 - FRAC_BITS;
  localparam int Z_W        = 31;
  localparam int ZI_W       = Z_W + 32;
  localparam int Q_W        = ZI_W - PRE_SHIFT;
  localparam int P_W        = Q_W + HALF_W;
  localparam int MAG_W      = P_W + 1 - POST_SHIFT;
  localparam logic [Z_W-1:0] Z_MAX = {Z_W{1'b1}};

  // Divider sequencing.
  localparam int DIV_STEPS = 32;
  localparam int DIVCNT_W  = $clog2(DIV_STEPS);

  // Queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Register reset values.
  localparam logic [31:0]       RST_DEPTH_SCALE  = 32'd25534815;
  localparam logic [31:0]       RST_INV_FOCAL_X  = 32'd5952395;
  localparam logic [31:0]       RST_INV_FOCAL_Y  = 32'd5952395;
  localparam logic [HALF_W-1:0] RST_CENTER_COL   = 14'd1242;
  localparam logic [HALF_W-1:0] RST_CENTER_ROW   = 14'd375;
  localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 13'd1242;
  localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 13'd375;

  typedef enum logic [2:0] {
    REG_DEPTH_SCALE  = 3'd0,
    REG_INV_FOCAL_X  = 3'd1,
    REG_INV_FOCAL_Y  = 3'd2,
    REG_CENTER_COL   = 3'd3,
    REG_CENTER_ROW   = 3'd4,
    REG_FRAME_WIDTH  = 3'd5,
    REG_FRAME_HEIGHT = 3'd6
  } dtp_reg_e;

  typedef struct packed {
    logic [31:0]       depth_scale;
    logic [31:0]       inv_focal_x;
    logic [31:0]       inv_focal_y;
    logic [HALF_W-1:0] center_col_half;
    logic [HALF_W-1:0] center_row_half;
    logic [DIM_W-1:0]  frame_width;
    logic [DIM_W-1:0]  frame_height;
  } dtp_cfg_t;

  // One pixel as classified by the front part.
  typedef struct packed {
    logic [7:0]       disparity;
    logic             depth_ok;
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
    logic [23:0]      rgb;
    logic             last;
  } dtp_item_t;

endpackage

FILE: rtl/dtp_if.sv
// Pixel input channel.
interface dtp_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] disparity;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;

  modport source (output valid, output disparity, output blue, output green, output red,
                  input ready);
  modport sink (input valid, input disparity, input blue, input green, input red,
                output ready);
endinterface

// Point output channel.
interface dtp_pnt_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic [30:0]        point_z;
  logic [23:0]        color_rgb;
  logic               depth_valid;
  logic               frame_last;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output color_rgb, output depth_valid, output frame_last, input ready);
  modport sink (input valid, input point_x, input point_y, input point_z,
                input color_rgb, input depth_valid, input frame_last, output ready);
endinterface

// Register write channel.
interface dtp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/disparity_to_point_reprojection.sv
// Reprojects a raster stream of disparity and colour pixels to 3-D points in
// signed Q16.16. A front stage tracks column and row, wrapping at the
// programmed frame size, and feeds a four-entry queue; a back stage divides
// depth_scale by the disparity one quotient bit per cycle, then forms x and y
// through two registered multiplies and rounds and saturates them. A pixel
// with nonzero disparity passes through the serial divider and both
// multiplies, a pixel with zero disparity goes straight to the output; the
// front keeps taking transactions until the queue is full, and a finished
// point waits in the output register while the next one is computed.
// Registers are written through the configuration channel and should only
// change while the block has no pixel in flight.
module disparity_to_point_reprojection (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtp_pix_if.sink   pix_i,
  dtp_pnt_if.source pnt_o,
  dtp_cfg_if.sink   cfg_i
);
  import dtp_pkg::*;

  dtp_cfg_t  cfg_q;
  dtp_item_t push_item, pop_item;
  logic      push, pop, full, empty;

  // Register file; writes are always taken, unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth_scale     <= RST_DEPTH_SCALE;
      cfg_q.inv_focal_x     <= RST_INV_FOCAL_X;
      cfg_q.inv_focal_y     <= RST_INV_FOCAL_Y;
      cfg_q.center_col_half <= RST_CENTER_COL;
      cfg_q.center_row_half <= RST_CENTER_ROW;
      cfg_q.frame_width     <= RST_FRAME_WIDTH;
      cfg_q.frame_height    <= RST_FRAME_HEIGHT;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_DEPTH_SCALE:  cfg_q.depth_scale     <= cfg_i.data;
        REG_INV_FOCAL_X:  cfg_q.inv_focal_x     <= cfg_i.data;
        REG_INV_FOCAL_Y:  cfg_q.inv_focal_y     <= cfg_i.data;
        REG_CENTER_COL:   cfg_q.center_col_half <= cfg_i.data[HALF_W-1:0];
        REG_CENTER_ROW:   cfg_q.center_row_half <= cfg_i.data[HALF_W-1:0];
        REG_FRAME_WIDTH:  cfg_q.frame_width     <= cfg_i.data[DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg_q.frame_height    <= cfg_i.data[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dtp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .pix_i  (pix_i),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  dtp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (pop_item),
    .empty_o (empty)
  );

  dtp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .item_i  (pop_item),
    .pop_o   (pop),
    .pnt_o   (pnt_o)
  );

endmodule

FILE: rtl/dtp_front.sv
module dtp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dtp_pkg::dtp_cfg_t cfg_i,
  dtp_pix_if.sink          pix_i,
  input  logic             full_i,
  output logic             push_o,
  output dtp_pkg::dtp_item_t item_o
);
  import dtp_pkg::*;

  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic [DIM_W-1:0] eff_w, eff_h;
  logic             row_end, col_end;

  // A frame size of zero acts as one, anything above the limit as the limit.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return v;
  endfunction

  assign eff_w   = eff_dim(cfg_i.frame_width);
  assign eff_h   = eff_dim(cfg_i.frame_height);
  assign row_end = (DIM_W'(col_q) + DIM_W'(1)) >= eff_w;
  assign col_end = (DIM_W'(row_q) + DIM_W'(1)) >= eff_h;

  // A transaction is taken whenever the queue has room.
  assign pix_i.ready = !full_i;
  assign push_o      = pix_i.valid && !full_i;

  // Classify the pixel and tag it with its position.
  always_comb begin
    item_o.disparity = pix_i.disparity;
    item_o.depth_ok  = pix_i.disparity != 8'd0;
    item_o.col       = col_q;
    item_o.row       = row_q;
    item_o.rgb       = {pix_i.red, pix_i.green, pix_i.blue};
    item_o.last      = row_end && col_end;
  end

  // Raster position counters.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (row_end) begin
        col_d = '0;
        row_d = col_end ? '0 : row_q + CNT_W'(1);
      end else begin
        col_d = col_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

FILE: rtl/dtp_queue.sv
module dtp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  dtp_pkg::dtp_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output dtp_pkg::dtp_item_t item_o,
  output logic               empty_o
);
  import dtp_pkg::*;

  dtp_item_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign full_o  = count_q == (QPTR_W + 1)'(QDEPTH);
  assign empty_o = count_q == '0;
  assign item_o  = mem_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QPTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QPTR_W + 1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/dtp_back.sv
module dtp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dtp_pkg::dtp_cfg_t  cfg_i,
  input  logic               empty_i,
  input  dtp_pkg::dtp_item_t item_i,
  output logic               pop_o,
  dtp_pnt_if.source          pnt_o
);
  import dtp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_MULQ = 5'b00100,
    ST_MULD = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [DIVCNT_W-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                load_out;

  dtp_item_t           item_q, item_d;
  logic [7:0]          rem_q, rem_d;
  logic [31:0]         quo_q, quo_d;
  logic [Z_W-1:0]      z_q, z_d;
  logic [Q_W-1:0]      qx_q, qx_d, qy_q, qy_d;
  logic [HALF_W-1:0]   dux_q, dux_d, duy_q, duy_d;
  logic                negx_q, negx_d, negy_q, negy_d;
  logic [P_W-1:0]      px_q, px_d, py_q, py_d;

  logic signed [31:0]  out_x_q, out_y_q;
  logic [Z_W-1:0]      out_z_q;
  logic [23:0]         out_rgb_q;
  logic                out_dv_q, out_last_q;

  logic [8:0]          trial;
  logic                ge;
  logic [Z_W-1:0]      z_sat;
  logic [ZI_W-1:0]     zix, ziy;
  logic [HALF_W-1:0]   twice_c, twice_r;
  logic [P_W:0]        rnd_x, rnd_y;
  logic signed [31:0]  lat_x, lat_y;

  // Saturate a rounded magnitude with its sign to a signed 32-bit value.
  function automatic logic signed [31:0] sat_lat(input logic [MAG_W-1:0] mag, input logic neg);
    if (neg) begin
      if (mag > MAG_W'(33'h080000000)) begin
        return 32'sh80000000;
      end
      return 32'(32'd0 - mag[31:0]);
    end
    if (mag > MAG_W'(32'h7FFFFFFF)) begin
      return 32'sh7FFFFFFF;
    end
    return mag[31:0];
  endfunction

  // Restoring division step, one quotient bit per cycle.
  assign trial = {rem_q, quo_q[31]};
  assign ge    = trial >= {1'b0, item_q.disparity};
  assign z_sat = quo_q[31] ? Z_MAX : quo_q[Z_W-1:0];

  // Depth times reciprocal focal length, and half-pixel offsets.
  assign zix     = ZI_W'(z_sat) * ZI_W'(cfg_i.inv_focal_x);
  assign ziy     = ZI_W'(z_sat) * ZI_W'(cfg_i.inv_focal_y);
  assign twice_c = {1'b0, item_q.col, 1'b0};
  assign twice_r = {1'b0, item_q.row, 1'b0};

  // Round half away from zero on the magnitude, then saturate.
  assign rnd_x = (P_W + 1)'(px_q) + (P_W + 1)'(1 << (POST_SHIFT - 1));
  assign rnd_y = (P_W + 1)'(py_q) + (P_W + 1)'(1 << (POST_SHIFT - 1));
  assign lat_x = sat_lat(rnd_x[P_W:POST_SHIFT], negx_q);
  assign lat_y = sat_lat(rnd_y[P_W:POST_SHIFT], negy_q);

  // The output register is free when empty or being emptied this cycle.
  assign load_out = (state_q == ST_FIN) && (!out_valid_q || pnt_o.ready);
  assign pop_o    = (state_q == ST_IDLE) && !empty_i;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    item_d      = item_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    z_d         = z_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    dux_d       = dux_q;
    duy_d       = duy_q;
    negx_d      = negx_q;
    negy_d      = negy_q;
    px_d        = px_q;
    py_d        = py_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && pnt_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          item_d = item_i;
          if (item_i.depth_ok) begin
            rem_d   = '0;
            quo_d   = cfg_i.depth_scale;
            cnt_d   = '0;
            state_d = ST_DIV;
          end else begin
            // Unknown depth: saturated z, lateral values round to zero.
            z_d     = Z_MAX;
            px_d    = '0;
            py_d    = '0;
            negx_d  = 1'b0;
            negy_d  = 1'b0;
            state_d = ST_FIN;
          end
        end
      end
      ST_DIV: begin
        rem_d = ge ? 8'(trial - {1'b0, item_q.disparity}) : trial[7:0];
        quo_d = {quo_q[30:0], ge};
        cnt_d = cnt_q + DIVCNT_W'(1);
        if (cnt_q == DIVCNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_MULQ;
        end
      end
      ST_MULQ: begin
        z_d     = z_sat;
        qx_d    = zix[ZI_W-1:PRE_SHIFT];
        qy_d    = ziy[ZI_W-1:PRE_SHIFT];
        negx_d  = twice_c < cfg_i.center_col_half;
        negy_d  = twice_r < cfg_i.center_row_half;
        dux_d   = (twice_c < cfg_i.center_col_half) ? cfg_i.center_col_half - twice_c
                                                    : twice_c - cfg_i.center_col_half;
        duy_d   = (twice_r < cfg_i.center_row_half) ? cfg_i.center_row_half - twice_r
                                                    : twice_r - cfg_i.center_row_half;
        state_d = ST_MULD;
      end
      ST_MULD: begin
        px_d    = P_W'(qx_q) * P_W'(dux_q);
        py_d    = P_W'(qy_q) * P_W'(duy_q);
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    z_q    <= z_d;
    qx_q   <= qx_d;
    qy_q   <= qy_d;
    dux_q  <= dux_d;
    duy_q  <= duy_d;
    negx_q <= negx_d;
    negy_q <= negy_d;
    px_q   <= px_d;
    py_q   <= py_d;
    if (load_out) begin
      out_x_q    <= lat_x;
      out_y_q    <= lat_y;
      out_z_q    <= z_q;
      out_rgb_q  <= item_q.rgb;
      out_dv_q   <= item_q.depth_ok;
      out_last_q <= item_q.last;
    end
  end

  assign pnt_o.valid       = out_valid_q;
  assign pnt_o.point_x     = out_x_q;
  assign pnt_o.point_y     = out_y_q;
  assign pnt_o.point_z     = out_z_q;
  assign pnt_o.color_rgb   = out_rgb_q;
  assign pnt_o.depth_valid = out_dv_q;
  assign pnt_o.frame_last  = out_last_q;

endmodule

FILE: test/dtp_point_checker.sv
// Watches the pixel, point and register channels of the reprojection block.
// It keeps its own copy of the registers and of the raster position, predicts
// the point for every accepted pixel transaction and compares each accepted
// point transaction with the oldest prediction.
module dtp_point_checker (
  input  logic clk_i,
  input  logic rst_ni,
  dtp_pix_if   pix_i,
  dtp_pnt_if   pnt_i,
  dtp_cfg_if   cfg_i,
  output int   err_cnt_o,
  output int   pending_o
);
  import dtp_pkg::*;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [Z_W-1:0]     z;
    logic [23:0]        rgb;
    logic               depth_ok;
    logic               last;
  } point_t;

  point_t           expected_points[$];
  dtp_cfg_t         regs;
  logic [CNT_W-1:0] col_q;
  logic [CNT_W-1:0] row_q;

  // A programmed size of zero behaves as one, anything above the maximum as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (v > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return v;
  endfunction

  // Offset from the principal point times depth times 1/f, rounded half away
  // from zero and saturated to a signed 32-bit value.
  function automatic logic [31:0] lateral_coord(input logic [CNT_W-1:0] pos,
                                                input logic [HALF_W-1:0] ctr,
                                                input logic [63:0] z,
                                                input logic [31:0] inv);
    logic [63:0] q;
    logic [63:0] twice;
    logic [63:0] du;
    logic [63:0] mag;
    logic        neg;
    q     = (z * {32'd0, inv}) >> PRE_SHIFT;
    twice = {52'd0, pos} << 1;
    neg   = twice < {50'd0, ctr};
    du    = neg ? ({50'd0, ctr} - twice) : (twice - {50'd0, ctr});
    mag   = (q * du + (64'd1 << (POST_SHIFT - 1))) >> POST_SHIFT;
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      mag = 64'd0 - mag;
      return mag[31:0];
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  // Point expected for one pixel at the current raster position.
  function automatic point_t project_pixel(input logic [7:0] d, b, g, r, input logic last);
    point_t      pt;
    logic [63:0] z;
    z    = {33'd0, Z_MAX};
    pt.x = '0;
    pt.y = '0;
    if (d != 8'd0) begin
      z = {32'd0, regs.depth_scale} / {56'd0, d};
      if (z > {33'd0, Z_MAX}) z = {33'd0, Z_MAX};
      pt.x = lateral_coord(col_q, regs.center_col_half, z, regs.inv_focal_x);
      pt.y = lateral_coord(row_q, regs.center_row_half, z, regs.inv_focal_y);
    end
    pt.z        = z[Z_W-1:0];
    pt.rgb      = {r, g, b};
    pt.depth_ok = d != 8'd0;
    pt.last     = last;
    return pt;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      err_cnt_o++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    point_t           exp_pt;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic             row_end;
    logic             col_end;
    if (!rst_ni) begin
      expected_points.delete();
      regs.depth_scale     = RST_DEPTH_SCALE;
      regs.inv_focal_x     = RST_INV_FOCAL_X;
      regs.inv_focal_y     = RST_INV_FOCAL_Y;
      regs.center_col_half = RST_CENTER_COL;
      regs.center_row_half = RST_CENTER_ROW;
      regs.frame_width     = RST_FRAME_WIDTH;
      regs.frame_height    = RST_FRAME_HEIGHT;
      col_q                = '0;
      row_q                = '0;
      err_cnt_o            = 0;
      pending_o           <= 0;
    end else begin
      // Compare a finished point with the oldest prediction.
      if (pnt_i.valid && pnt_i.ready) begin
        if (expected_points.size() == 0) begin
          err_cnt_o++;
          $display("%0t: point with no pixel waiting, x %h y %h z %h rgb %h valid %b last %b",
                   $time, pnt_i.point_x, pnt_i.point_y, pnt_i.point_z, pnt_i.color_rgb,
                   pnt_i.depth_valid, pnt_i.frame_last);
        end else begin
          exp_pt = expected_points.pop_front();
          check_field("point_x", exp_pt.x, pnt_i.point_x);
          check_field("point_y", exp_pt.y, pnt_i.point_y);
          check_field("point_z", 32'(exp_pt.z), 32'(pnt_i.point_z));
          check_field("color_rgb", 32'(exp_pt.rgb), 32'(pnt_i.color_rgb));
          check_field("depth_valid", 32'(exp_pt.depth_ok), 32'(pnt_i.depth_valid));
          check_field("frame_last", 32'(exp_pt.last), 32'(pnt_i.frame_last));
        end
      end

      // Register writes keep only the width of the register.
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_DEPTH_SCALE:  regs.depth_scale     = cfg_i.data;
          REG_INV_FOCAL_X:  regs.inv_focal_x     = cfg_i.data;
          REG_INV_FOCAL_Y:  regs.inv_focal_y     = cfg_i.data;
          REG_CENTER_COL:   regs.center_col_half = cfg_i.data[HALF_W-1:0];
          REG_CENTER_ROW:   regs.center_row_half = cfg_i.data[HALF_W-1:0];
          REG_FRAME_WIDTH:  regs.frame_width     = cfg_i.data[DIM_W-1:0];
          REG_FRAME_HEIGHT: regs.frame_height    = cfg_i.data[DIM_W-1:0];
          default: ;
        endcase
      end

      // Predict each accepted pixel, then advance the raster position. A counter
      // already at or past a shrunken size ends its row or frame and wraps.
      if (pix_i.valid && pix_i.ready) begin
        w       = clamp_dim(regs.frame_width);
        h       = clamp_dim(regs.frame_height);
        row_end = ({1'b0, col_q} + DIM_W'(1)) >= w;
        col_end = ({1'b0, row_q} + DIM_W'(1)) >= h;
        expected_points.insert(expected_points.size(),
                               project_pixel(pix_i.disparity, pix_i.blue, pix_i.green,
                                             pix_i.red, row_end && col_end));
        if (row_end) begin
          col_q = '0;
          row_q = col_end ? '0 : row_q + CNT_W'(1);
        end else begin
          col_q = col_q + CNT_W'(1);
        end
      end

      pending_o <= expected_points.size();
    end
  end

endmodule

FILE: test/disparity_to_point_reprojection_test.sv
// Drives pixels and register writes into the reprojection block with random
// gaps and back-pressure; the checker beside it predicts and compares.
module disparity_to_point_reprojection_test;
  import dtp_pkg::*;

  localparam int         CYCLE_LIMIT   = 1_000_000;
  localparam int         DRAIN_CYCLES  = 48;
  localparam int         HOLD_CYCLES   = 400;
  localparam int         HOLD_AT       = 300;
  localparam int         RANDOM_PHASES = 9;
  localparam int         PHASE_PIXELS  = 65;
  localparam logic [2:0] REG_UNUSED    = 3'd7;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   points_pending;
  int   point_errors;
  int   pixels_sent   = 0;
  int   zero_pixels   = 0;
  int   settings_done = 0;
  int   cycle_count   = 0;
  bit   steady        = 1'b0;

  dtp_pix_if pix_if ();
  dtp_pnt_if pnt_if ();
  dtp_cfg_if cfg_if ();

  disparity_to_point_reprojection u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .pnt_o  (pnt_if),
    .cfg_i  (cfg_if)
  );

  dtp_point_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_if),
    .pnt_i     (pnt_if),
    .cfg_i     (cfg_if),
    .err_cnt_o (point_errors),
    .pending_o (points_pending)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Idle lengths: mostly none, sometimes a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // Scale and reciprocal focal values, extremes included.
  function automatic logic [31:0] pick_coeff();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 32'd0;
    if (sel == 1) return 32'hFFFF_FFFF;
    if (sel < 5) return $urandom;
    return $urandom_range(1 << 26, 1 << 20);
  endfunction

  // Principal point in half pixels, with junk above the register width.
  function automatic logic [31:0] pick_center();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0:       v = 32'd0;
      1:       v = 32'h3FFF;
      2:       v = $urandom_range(0, 16383);
      default: v = $urandom_range(0, 24);
    endcase
    return v | ($urandom & 32'hFFFF_C000);
  endfunction

  // Frame sizes are mostly tiny so that frame ends come often.
  function automatic logic [31:0] pick_dim();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0:       v = 32'd0;
      1:       v = $urandom_range(MAX_DIM + 1, 8191);
      2:       v = $urandom_range(1, 8191);
      default: v = $urandom_range(1, 8);
    endcase
    return v | ($urandom & 32'hFFFF_E000);
  endfunction

  // Offer one pixel after an optional gap and hold it until the transaction.
  task automatic send_pixel(input logic [7:0] d, b, g, r);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid     <= 1'b1;
    pix_if.disparity <= d;
    pix_if.blue      <= b;
    pix_if.green     <= g;
    pix_if.red       <= r;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    pixels_sent++;
    if (d == 8'd0) zero_pixels++;
  endtask

  // Leaves valid high so that back-to-back writes need no second assignment.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  // Wait until every predicted point has come out, then let the pipeline settle.
  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (points_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [31:0] ds, ifx, ify, ccol, crow, fw, fh);
    wait_drained();
    write_reg(REG_DEPTH_SCALE, ds);
    write_reg(REG_INV_FOCAL_X, ifx);
    write_reg(REG_INV_FOCAL_Y, ify);
    write_reg(REG_CENTER_COL, ccol);
    write_reg(REG_CENTER_ROW, crow);
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    // An unused index must not disturb any register.
    write_reg(REG_UNUSED, $urandom);
    cfg_if.valid <= 1'b0;
    settings_done++;
  endtask

  // Point receiver: random stalls, plus one long hold-off while pixels keep coming.
  initial begin : point_sink
    int hold;
    bit held_long;
    hold      = 0;
    held_long = 1'b0;
    pnt_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held_long && pixels_sent >= HOLD_AT) begin
        held_long = 1'b1;
        pnt_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        pnt_if.ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        pnt_if.ready <= 1'b0;
      end else if (steady || $urandom_range(0, 99) < 70) begin
        pnt_if.ready <= 1'b1;
      end else begin
        pnt_if.ready <= 1'b0;
        hold = pick_gap();
      end
    end
  end

  // Cycle counter that ends a hung run.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d points outstanding.",
             cycle_count, points_pending);
    $display("disparity_to_point_reprojection_test: errors");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] d;
    int         pick;
    pix_if.valid     <= 1'b0;
    pix_if.disparity <= '0;
    pix_if.blue      <= '0;
    pix_if.green     <= '0;
    pix_if.red       <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= '0;
    cfg_if.data      <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: unknown depth, smallest and largest disparity, colour extremes.
    send_pixel(8'd0, 8'h00, 8'h00, 8'h00);
    send_pixel(8'd1, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd255, 8'h55, 8'hAA, 8'h0F);
    send_pixel(8'd128, 8'hA5, 8'h0F, 8'hF0);

    // Mostly at the top, height above the maximum: z saturates at low disparity and
    // x, y off centre; width zero acts as one, so the column past it ends the row.
    apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
                  32'd0, 32'hFFFF_FFFF);
    send_pixel(8'd1, 8'h12, 8'h34, 8'h56);
    send_pixel(8'd1, 8'hFE, 8'h01, 8'h80);
    send_pixel(8'd1, 8'h7F, 8'h80, 8'h01);
    send_pixel(8'd255, 8'h00, 8'hFF, 8'h00);
    send_pixel(8'd0, 8'hFF, 8'h00, 8'hFF);
    send_pixel(8'd2, 8'h3C, 8'hC3, 8'h99);

    // Everything at zero on a 3 x 2 frame: the row counter left over from the
    // tall frame lies past the new height, so the current row ends the frame.
    apply_setting(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd3, 32'd2);
    for (int i = 0; i < 8; i++) begin
      send_pixel(i[0] ? 8'd0 : 8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end

    // Random settings, each followed by a run of random pixels.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_setting(pick_coeff(), pick_coeff(), pick_coeff(), pick_center(), pick_center(),
                    pick_dim(), pick_dim());
      steady = (p % 3 == 2);
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        pick = $urandom_range(0, 19);
        if (pick < 2) d = 8'd0;
        else if (pick == 2) d = 8'd1;
        else if (pick == 3) d = 8'd255;
        else if (pick < 7) d = 8'($urandom_range(1, 8));
        else d = 8'($urandom_range(0, 255));
        send_pixel(d, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      end
      steady = 1'b0;
    end

    wait_drained();
    $display("Sent %0d pixels (%0d with zero disparity) under %0d register settings,",
             pixels_sent, zero_pixels, settings_done + 1);
    $display("with random gaps on both channels and one long stall of the point output.");
    if (point_errors == 0 && points_pending == 0) begin
      $display("disparity_to_point_reprojection_test: clean");
    end else begin
      $display("disparity_to_point_reprojection_test: errors");
    end
    $finish;
  end

endmodule
